@@ rtl/ngtdm_matrix_accumulator_unit_macros.svh @@
// assertion macros for the accumulator unit
`ifndef NGTDM_MATRIX_ACCUMULATOR_UNIT_MACROS_SVH
`define NGTDM_MATRIX_ACCUMULATOR_UNIT_MACROS_SVH

// condition holds at every edge outside reset
`define NGTDM_CHECK(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ngtdm invariant violated");

// antecedent implies consequent in the same cycle
`define NGTDM_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ngtdm implication violated");

// antecedent implies consequent in the following cycle
`define NGTDM_IMPLY_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ngtdm sequence violated");

`endif

@@ rtl/ngtdm_pkg.sv @@
package ngtdm_pkg;

    // table and arithmetic sizing
    localparam int MAX_LEVELS = 256;
    localparam int LEVEL_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int COUNT_BITS = 24;
    localparam int DIFF_BITS  = 48;
    localparam int AVG_BITS   = 24;
    localparam int ROW_BITS   = $clog2(MAX_LEVELS);
    localparam int TOTAL_BITS = $clog2(MAX_LEVELS + 1);
    localparam int SCALE_BITS = LEVEL_BITS + FRAC_BITS;
    localparam int DELTA_BITS = (SCALE_BITS > AVG_BITS) ? SCALE_BITS : AVG_BITS;
    localparam int ALU_BITS   = DIFF_BITS;
    localparam int ROW_WIDTH  = COUNT_BITS + DIFF_BITS;

    // item kinds on the input channel
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_VOXEL  = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode        mode;
        logic [15:0]  level;
        logic [23:0]  neighbor_average;
        logic [7:0]   row_index;
    } t_in_beat;

    typedef struct packed {
        logic [15:0]  row_level;
        logic [23:0]  row_count;
        logic [47:0]  row_diff_sum;
        logic [23:0]  total_voxels;
        logic [23:0]  positive_mean_voxels;
        logic [8:0]   levels_loaded;
        logic         level_missed;
    } t_out_beat;

    // shared add/subtract unit
    typedef enum logic {
        ALU_SUB = 1'b0,
        ALU_ADD = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op             op;
        logic [ALU_BITS-1:0] a;
        logic [ALU_BITS-1:0] b;
    } t_alu_req;

    // carry is the borrow for a subtraction (a below b)
    typedef struct packed {
        logic [ALU_BITS-1:0] res;
        logic                carry;
    } t_alu_rsp;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (&v) ? v : v + COUNT_BITS'(1);
        return r;
    endfunction

endpackage

@@ rtl/ngtdm_ram.sv @@
module ngtdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ngtdm_alu.sv @@
module ngtdm_alu (
    input  ngtdm_pkg::t_alu_req i_req,
    output ngtdm_pkg::t_alu_rsp o_rsp
);

    logic [ngtdm_pkg::ALU_BITS:0] wide;

    // one wide adder, used for compares, differences and sums
    always_comb begin
        unique case (i_req.op)
            ngtdm_pkg::ALU_SUB: wide = {1'b0, i_req.a} - {1'b0, i_req.b};
            ngtdm_pkg::ALU_ADD: wide = {1'b0, i_req.a} + {1'b0, i_req.b};
            default:            wide = '0;
        endcase
    end

    assign o_rsp.res   = wide[ngtdm_pkg::ALU_BITS-1:0];
    assign o_rsp.carry = wide[ngtdm_pkg::ALU_BITS];

endmodule

@@ rtl/ngtdm_matrix_accumulator_unit.sv @@
// NGTDM accumulator: builds the grey tone difference table for software.
// Input channel (i_in_valid / o_in_stall, payload i_in_beat) takes one item per
// beat: clear, append a level to the sorted level table, add a voxel, or query
// a row. Only a query gives a result beat on o_out_valid / i_out_stall.
// Clear and append finish in the cycle they are accepted and leave the input
// free for the next beat.
// A voxel is a lower-bound bisection over the loaded levels, each step a
// memory read, then a compare in the shared adder; then a check, the absolute
// difference and a saturating read-modify-write of the row, with the input
// stalled until the voxel ends. A voxel whose level is absent sets the miss
// flag and ends at the check, or after the search if it lies above all levels.
// A query reads both memories, then loads the result beat into the output
// register once the output is free, which raises o_out_valid.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, the beat holds and a further query waits for it.
// Reset zeroes the counters, totals, miss flag and row valid bits. The level
// memory is not cleared; entries past the fill count never reach a result.
module ngtdm_matrix_accumulator_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ngtdm_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ngtdm_pkg::t_out_beat o_out_beat
);

    `include "ngtdm_matrix_accumulator_unit_macros.svh"

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SRCH     = 9'b000000010,
        S_SRCH_CMP = 9'b000000100,
        S_CHK      = 9'b000001000,
        S_DIFF_A   = 9'b000010000,
        S_DIFF_B   = 9'b000100000,
        S_ADD      = 9'b001000000,
        S_QRY_RD   = 9'b010000000,
        S_QRY_OUT  = 9'b100000000
    } t_state;

    t_state                                r_state, n_state;
    logic [ngtdm_pkg::TOTAL_BITS-1:0]      r_level_total, n_level_total;
    logic [ngtdm_pkg::COUNT_BITS-1:0]      r_vox_total, n_vox_total;
    logic [ngtdm_pkg::COUNT_BITS-1:0]      r_pos_total, n_pos_total;
    logic                                  r_miss, n_miss;
    logic [ngtdm_pkg::MAX_LEVELS-1:0]      r_row_vld, n_row_vld;
    logic                                  r_out_valid, n_out_valid;
    logic [ngtdm_pkg::TOTAL_BITS-1:0]      r_lo, n_lo;
    logic [ngtdm_pkg::TOTAL_BITS-1:0]      r_hi, n_hi;
    logic [ngtdm_pkg::TOTAL_BITS-1:0]      r_mid, n_mid;
    logic [ngtdm_pkg::LEVEL_BITS-1:0]      r_lvl, n_lvl;
    logic [ngtdm_pkg::AVG_BITS-1:0]        r_avg, n_avg;
    logic [ngtdm_pkg::ROW_BITS-1:0]        r_ridx, n_ridx;
    logic [ngtdm_pkg::COUNT_BITS-1:0]      r_cnt, n_cnt;
    logic [ngtdm_pkg::DIFF_BITS-1:0]       r_sum, n_sum;
    logic [ngtdm_pkg::DELTA_BITS-1:0]      r_diff, n_diff;
    logic                                  r_rd_vld, n_rd_vld;
    logic                                  r_q_hit, n_q_hit;
    ngtdm_pkg::t_out_beat                  r_out_beat, n_out_beat;

    // memory ports
    logic                                  lvl_we, lvl_re;
    logic [ngtdm_pkg::ROW_BITS-1:0]        lvl_waddr, lvl_raddr;
    logic [ngtdm_pkg::LEVEL_BITS-1:0]      lvl_wdata, lvl_rdata;
    logic                                  row_we, row_re;
    logic [ngtdm_pkg::ROW_BITS-1:0]        row_waddr, row_raddr;
    logic [ngtdm_pkg::ROW_WIDTH-1:0]       row_wdata, row_rdata;

    ngtdm_pkg::t_alu_req                   alu_req;
    ngtdm_pkg::t_alu_rsp                   alu_rsp;

    logic                                  in_take;
    logic                                  out_free;
    logic [ngtdm_pkg::TOTAL_BITS:0]        mid_sum;
    logic [ngtdm_pkg::ALU_BITS-1:0]        scaled;
    logic [ngtdm_pkg::COUNT_BITS-1:0]      rd_cnt;
    logic [ngtdm_pkg::DIFF_BITS-1:0]       rd_sum;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign scaled     = ngtdm_pkg::ALU_BITS'(r_lvl) << ngtdm_pkg::FRAC_BITS;
    assign rd_cnt     = row_rdata[ngtdm_pkg::ROW_WIDTH-1 -: ngtdm_pkg::COUNT_BITS];
    assign rd_sum     = row_rdata[ngtdm_pkg::DIFF_BITS-1:0];

    // level table
    ngtdm_ram #(
        .WIDTH (ngtdm_pkg::LEVEL_BITS),
        .DEPTH (ngtdm_pkg::MAX_LEVELS)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_re    (lvl_re),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    // count and difference sum per row
    ngtdm_ram #(
        .WIDTH (ngtdm_pkg::ROW_WIDTH),
        .DEPTH (ngtdm_pkg::MAX_LEVELS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    ngtdm_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // sequencer and datapath next state
    always_comb begin
        n_state       = r_state;
        n_level_total = r_level_total;
        n_vox_total   = r_vox_total;
        n_pos_total   = r_pos_total;
        n_miss        = r_miss;
        n_row_vld     = r_row_vld;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mid         = r_mid;
        n_lvl         = r_lvl;
        n_avg         = r_avg;
        n_ridx        = r_ridx;
        n_cnt         = r_cnt;
        n_sum         = r_sum;
        n_diff        = r_diff;
        n_rd_vld      = r_rd_vld;
        n_q_hit       = r_q_hit;
        n_out_beat    = r_out_beat;
        n_out_valid   = r_out_valid && i_out_stall;

        lvl_we    = 1'b0;
        lvl_waddr = r_level_total[ngtdm_pkg::ROW_BITS-1:0];
        lvl_wdata = i_in_beat.level[ngtdm_pkg::LEVEL_BITS-1:0];
        lvl_re    = 1'b0;
        lvl_raddr = r_lo[ngtdm_pkg::ROW_BITS-1:0];
        row_we    = 1'b0;
        row_waddr = r_lo[ngtdm_pkg::ROW_BITS-1:0];
        row_wdata = '0;
        row_re    = 1'b0;
        row_raddr = r_lo[ngtdm_pkg::ROW_BITS-1:0];

        alu_req.op = ngtdm_pkg::ALU_SUB;
        alu_req.a  = ngtdm_pkg::ALU_BITS'(lvl_rdata);
        alu_req.b  = ngtdm_pkg::ALU_BITS'(r_lvl);

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    unique case (i_in_beat.mode)
                        ngtdm_pkg::MODE_CLEAR: begin
                            n_level_total = '0;
                            n_vox_total   = '0;
                            n_pos_total   = '0;
                            n_miss        = 1'b0;
                            n_row_vld     = '0;
                        end
                        ngtdm_pkg::MODE_APPEND: begin
                            if (r_level_total < ngtdm_pkg::TOTAL_BITS'(ngtdm_pkg::MAX_LEVELS)) begin
                                lvl_we        = 1'b1;
                                n_level_total = r_level_total + 1'b1;
                            end
                        end
                        ngtdm_pkg::MODE_VOXEL: begin
                            n_lvl   = i_in_beat.level[ngtdm_pkg::LEVEL_BITS-1:0];
                            n_avg   = i_in_beat.neighbor_average;
                            n_lo    = '0;
                            n_hi    = r_level_total;
                            n_state = S_SRCH;
                        end
                        ngtdm_pkg::MODE_QUERY: begin
                            n_ridx  = i_in_beat.row_index;
                            n_state = S_QRY_RD;
                        end
                        default: ;
                    endcase
                end
            end
            // bisection step: fetch the midpoint, or the final row, or end with a miss
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid     = mid_sum[ngtdm_pkg::TOTAL_BITS:1];
                    lvl_re    = 1'b1;
                    lvl_raddr = n_mid[ngtdm_pkg::ROW_BITS-1:0];
                    n_state   = S_SRCH_CMP;
                end else if (r_lo < r_level_total) begin
                    lvl_re   = 1'b1;
                    row_re   = 1'b1;
                    n_rd_vld = r_row_vld[row_raddr];
                    n_state  = S_CHK;
                end else begin
                    n_miss  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            // table entry below the level moves the lower bound up, else the upper bound down
            S_SRCH_CMP: begin
                if (alu_rsp.carry) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRCH;
            end
            // the found row must hold exactly this level
            S_CHK: begin
                if (alu_rsp.res == '0) begin
                    n_cnt   = r_rd_vld ? rd_cnt : '0;
                    n_sum   = r_rd_vld ? rd_sum : '0;
                    n_state = S_DIFF_A;
                end else begin
                    n_miss  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            // scaled level minus mean, reversed on borrow
            S_DIFF_A: begin
                alu_req.a = scaled;
                alu_req.b = ngtdm_pkg::ALU_BITS'(r_avg);
                n_diff    = alu_rsp.res[ngtdm_pkg::DELTA_BITS-1:0];
                n_state   = alu_rsp.carry ? S_DIFF_B : S_ADD;
            end
            S_DIFF_B: begin
                alu_req.a = ngtdm_pkg::ALU_BITS'(r_avg);
                alu_req.b = scaled;
                n_diff    = alu_rsp.res[ngtdm_pkg::DELTA_BITS-1:0];
                n_state   = S_ADD;
            end
            // saturating row update and totals
            S_ADD: begin
                alu_req.op = ngtdm_pkg::ALU_ADD;
                alu_req.a  = r_sum;
                alu_req.b  = ngtdm_pkg::ALU_BITS'(r_diff);
                row_we     = 1'b1;
                row_wdata  = {ngtdm_pkg::sat_inc(r_cnt),
                              alu_rsp.carry ? {ngtdm_pkg::DIFF_BITS{1'b1}} : alu_rsp.res};
                n_row_vld[row_waddr] = 1'b1;
                n_vox_total = ngtdm_pkg::sat_inc(r_vox_total);
                if (r_avg != '0) begin
                    n_pos_total = ngtdm_pkg::sat_inc(r_pos_total);
                end
                n_state = S_IDLE;
            end
            S_QRY_RD: begin
                lvl_re    = 1'b1;
                lvl_raddr = r_ridx;
                row_re    = 1'b1;
                row_raddr = r_ridx;
                n_rd_vld  = r_row_vld[row_raddr];
                n_q_hit   = ngtdm_pkg::TOTAL_BITS'(r_ridx) < r_level_total;
                n_state   = S_QRY_OUT;
            end
            // load the result beat once the output register is free
            S_QRY_OUT: begin
                if (out_free) begin
                    n_out_valid                     = 1'b1;
                    n_out_beat.row_level            = r_q_hit ? 16'(lvl_rdata) : '0;
                    n_out_beat.row_count            = (r_q_hit && r_rd_vld) ? 24'(rd_cnt) : '0;
                    n_out_beat.row_diff_sum         = (r_q_hit && r_rd_vld) ? 48'(rd_sum) : '0;
                    n_out_beat.total_voxels         = 24'(r_vox_total);
                    n_out_beat.positive_mean_voxels = 24'(r_pos_total);
                    n_out_beat.levels_loaded        = 9'(r_level_total);
                    n_out_beat.level_missed         = r_miss;
                    n_state                         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_level_total <= '0;
            r_vox_total   <= '0;
            r_pos_total   <= '0;
            r_miss        <= 1'b0;
            r_row_vld     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_level_total <= n_level_total;
            r_vox_total   <= n_vox_total;
            r_pos_total   <= n_pos_total;
            r_miss        <= n_miss;
            r_row_vld     <= n_row_vld;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_lvl      <= n_lvl;
        r_avg      <= n_avg;
        r_ridx     <= n_ridx;
        r_cnt      <= n_cnt;
        r_sum      <= n_sum;
        r_diff     <= n_diff;
        r_rd_vld   <= n_rd_vld;
        r_q_hit    <= n_q_hit;
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // checks
    `NGTDM_CHECK(a_fill_bound, r_level_total <= ngtdm_pkg::TOTAL_BITS'(ngtdm_pkg::MAX_LEVELS))
    `NGTDM_CHECK(a_pos_below_total, r_pos_total <= r_vox_total)
    `NGTDM_IMPLY(a_search_window, r_state == S_SRCH, (r_lo <= r_hi) && (r_hi <= r_level_total))
    `NGTDM_IMPLY(a_result_from_query, $rose(r_out_valid), $past(r_state == S_QRY_OUT))
    `NGTDM_IMPLY_NEXT(a_query_delivers, (r_state == S_QRY_OUT) && out_free, r_out_valid)

endmodule
